### rtl/asse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Array search and sort engine: shared definitions
// Operation and status codes, read-address selects, the input and result
// words and the command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
package asse_pkg;

    localparam int VAL_W = 32;
    localparam int POS_W = 7;

    // operations
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_LINEAR = 2'd2;
    localparam logic [1:0] OP_SORT   = 2'd3;

    // result status
    localparam logic [1:0] ST_ACCEPTED  = 2'd0;
    localparam logic [1:0] ST_FOUND     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // memory read-address selects
    localparam logic [1:0] RA_ZERO = 2'd0;
    localparam logic [1:0] RA_K1   = 2'd1;
    localparam logic [1:0] RA_K2   = 2'd2;
    localparam logic [1:0] RA_MID  = 2'd3;

    typedef struct packed {
        logic [1:0]              operation;
        logic signed [VAL_W-1:0] value;
    } t_cmd_word;

    typedef struct packed {
        logic [1:0]       status;
        logic [POS_W-1:0] position;
    } t_result_word;

    typedef struct packed {
        logic       ld_key;
        logic       do_clear;
        logic       do_append;
        logic [1:0] rsel;
        logic       sort_init;
        logic       ld_carry;
        logic       sort_step;
        logic       sort_end;
        logic       lin_init;
        logic       lin_step;
        logic       bin_init;
        logic       bin_load_mid;
        logic       bin_update;
        logic       fin;
        logic [1:0] fin_status;
    } t_dp_cmd;

    typedef struct packed {
        logic count_zero;
        logic count_lt2;
        logic full;
        logic k1_eq_lim;
        logic lim_gt1;
        logic lin_last;
        logic eq;
        logic bin_open;
    } t_dp_stat;

endpackage

### rtl/array_search_and_sort_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Array search and sort engine
// Holds up to DEPTH signed words; clears, appends, searches linearly, or
// bubble-sorts in place and then searches by bisection.
// ----------------------------------------------------------------------------
// Usage:
//   Present a command word on i_cmd with start high; it is taken on an edge
//   where busy is low. Exactly one result word follows on o_result, marked
//   by o_done for a single cycle; the receiver cannot hold it off.
//   Course of each command after the accepting edge:
//     clear, append           done in idle (busy never rises, next word at once)
//     linear search           reads from index 0 up to k, the index reached (at most
//                             count - 1); done in idle on an empty store
//     sort + binary search    one bubble pass per L = count-1 down to 1, then
//                             bisection steps (address, then compare) until
//                             a hit or until the bounds close on a miss.
//   The sequences are set by the single registered read port of the element
//   memory: the sort pass moves one word per cycle, carrying the larger one.
//   A new command may be presented in the cycle o_done is high.
//   Reset empties the store (count to zero) and returns the controller to
//   idle; memory contents are not cleared, and no unwritten word is used.
// ----------------------------------------------------------------------------
module array_search_and_sort_engine #(
    parameter int DEPTH = 128
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  asse_pkg::t_cmd_word    i_cmd,
    output logic                   o_done,
    output asse_pkg::t_result_word o_result
);
    import asse_pkg::*;

    t_dp_cmd  w_ctl;
    t_dp_stat w_stat;

    asse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_cmd.operation),
        .i_stat      (w_stat),
        .o_busy      (busy),
        .o_ctl       (w_ctl)
    );

    asse_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_ctl    (w_ctl),
        .o_stat   (w_stat),
        .o_done   (o_done),
        .o_result (o_result)
    );

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({w_ctl.do_append, w_ctl.sort_step, w_ctl.sort_end}) <= 1)
        else $error("more than one memory write in a cycle");

    a_quick_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd.operation == OP_CLEAR || i_cmd.operation == OP_APPEND))
        |=> (o_done && !busy))
        else $error("clear or append did not finish in one cycle");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while still busy");

    a_found_only_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != ST_FOUND) |-> (o_result.position == '0))
        else $error("position not zero without a match");

endmodule

### rtl/asse_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Array search and sort engine: datapath
// Element memory with one write and one registered read port, count, sort
// carry register, index registers, binary-search bounds and result register.
// ----------------------------------------------------------------------------
module asse_dpath #(
    parameter int DEPTH = 128
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  asse_pkg::t_cmd_word    i_cmd,
    input  asse_pkg::t_dp_cmd      i_ctl,
    output asse_pkg::t_dp_stat     o_stat,
    output logic                   o_done,
    output asse_pkg::t_result_word o_result
);
    import asse_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [VAL_W-1:0] r_mem [DEPTH];

    logic [CW-1:0]           r_count;
    logic signed [VAL_W-1:0] r_key;
    logic signed [VAL_W-1:0] r_carry;
    logic signed [VAL_W-1:0] r_rdata;
    logic [IW-1:0]           r_k;
    logic [IW-1:0]           r_lim;
    logic [CW-1:0]           r_lo;
    logic [CW-1:0]           r_hi;
    logic                    r_done;
    t_result_word            r_result;

    logic [IW-1:0]           w_raddr;
    logic [CW:0]             w_mid_sum;
    logic [IW-1:0]           w_mid;
    logic                    w_gt;
    logic signed [VAL_W-1:0] w_min;
    logic signed [VAL_W-1:0] w_max;

    // hi is kept exclusive, so the midpoint is (lo + hi - 1) / 2
    assign w_mid_sum = (CW+1)'(r_lo) + (CW+1)'(r_hi) - (CW+1)'(1);
    assign w_mid     = IW'(w_mid_sum >> 1);

    assign w_gt  = r_carry > r_rdata;
    assign w_min = w_gt ? r_rdata : r_carry;
    assign w_max = w_gt ? r_carry : r_rdata;

    always_comb begin
        unique case (i_ctl.rsel)
            RA_ZERO: w_raddr = '0;
            RA_K1:   w_raddr = r_k + IW'(1);
            RA_K2:   w_raddr = r_k + IW'(2);
            RA_MID:  w_raddr = w_mid;
            default: w_raddr = '0;
        endcase
    end

    // single write port: append, bubble step or end of pass
    always_ff @(posedge i_clk) begin
        if (i_ctl.do_append) begin
            r_mem[IW'(r_count)] <= i_cmd.value;
        end else if (i_ctl.sort_step) begin
            r_mem[r_k] <= w_min;
        end else if (i_ctl.sort_end) begin
            r_mem[r_lim] <= r_carry;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_ctl.fin;
            if (i_ctl.do_clear) begin
                r_count <= '0;
            end else if (i_ctl.do_append) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_key) begin
            r_key <= i_cmd.value;
        end
        if (i_ctl.sort_init) begin
            r_lim <= IW'(r_count - CW'(1));
            r_k   <= '0;
        end
        if (i_ctl.lin_init) begin
            r_k <= '0;
        end
        if (i_ctl.ld_carry) begin
            r_carry <= r_rdata;
        end
        // keep the larger value moving up the pass
        if (i_ctl.sort_step) begin
            r_carry <= w_max;
            r_k     <= r_k + IW'(1);
        end
        if (i_ctl.sort_end) begin
            r_lim <= r_lim - IW'(1);
            r_k   <= '0;
        end
        if (i_ctl.lin_step) begin
            r_k <= r_k + IW'(1);
        end
        if (i_ctl.bin_init) begin
            r_lo <= '0;
            r_hi <= r_count;
        end
        if (i_ctl.bin_load_mid) begin
            r_k <= w_mid;
        end
        if (i_ctl.bin_update) begin
            if (r_rdata < r_key) begin
                r_lo <= CW'(r_k) + CW'(1);
            end else begin
                r_hi <= CW'(r_k);
            end
        end
        if (i_ctl.fin) begin
            r_result.status   <= i_ctl.fin_status;
            r_result.position <= (i_ctl.fin_status == ST_FOUND) ? POS_W'(r_k) : '0;
        end
    end

    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.count_lt2  = (r_count < CW'(2));
    assign o_stat.full       = (r_count == CW'(DEPTH));
    assign o_stat.k1_eq_lim  = ((IW+1)'(r_k) + (IW+1)'(1)) == (IW+1)'(r_lim);
    assign o_stat.lim_gt1    = (r_lim > IW'(1));
    assign o_stat.lin_last   = (CW'(r_k) + CW'(1)) == r_count;
    assign o_stat.eq         = (r_rdata == r_key);
    assign o_stat.bin_open   = (r_lo < r_hi);

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

### rtl/asse_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Array search and sort engine: controller
// Decodes the accepted operation and sequences the linear search, the
// bubble-sort passes and the binary search over the datapath.
// ----------------------------------------------------------------------------
module asse_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [1:0]         i_operation,
    input  asse_pkg::t_dp_stat i_stat,
    output logic               o_busy,
    output asse_pkg::t_dp_cmd  o_ctl
);
    import asse_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LIN   = 3'd1;
    localparam logic [2:0] S_FIRST = 3'd2;
    localparam logic [2:0] S_STEP  = 3'd3;
    localparam logic [2:0] S_END   = 3'd4;
    localparam logic [2:0] S_BSET  = 3'd5;
    localparam logic [2:0] S_BADDR = 3'd6;
    localparam logic [2:0] S_BCMP  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.ld_key = 1'b1;
                    unique case (i_operation)
                        OP_CLEAR: begin
                            o_ctl.do_clear   = 1'b1;
                            o_ctl.fin        = 1'b1;
                            o_ctl.fin_status = ST_ACCEPTED;
                        end
                        OP_APPEND: begin
                            o_ctl.fin = 1'b1;
                            if (i_stat.full) begin
                                o_ctl.fin_status = ST_FULL;
                            end else begin
                                o_ctl.do_append  = 1'b1;
                                o_ctl.fin_status = ST_ACCEPTED;
                            end
                        end
                        OP_LINEAR: begin
                            if (i_stat.count_zero) begin
                                o_ctl.fin        = 1'b1;
                                o_ctl.fin_status = ST_NOT_FOUND;
                            end else begin
                                o_ctl.lin_init = 1'b1;
                                o_ctl.rsel     = RA_ZERO;
                                n_state        = S_LIN;
                            end
                        end
                        OP_SORT: begin
                            if (i_stat.count_lt2) begin
                                n_state = S_BSET;
                            end else begin
                                o_ctl.sort_init = 1'b1;
                                o_ctl.rsel      = RA_ZERO;
                                n_state         = S_FIRST;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_LIN: begin
                if (i_stat.eq) begin
                    o_ctl.fin        = 1'b1;
                    o_ctl.fin_status = ST_FOUND;
                    n_state          = S_IDLE;
                end else if (i_stat.lin_last) begin
                    o_ctl.fin        = 1'b1;
                    o_ctl.fin_status = ST_NOT_FOUND;
                    n_state          = S_IDLE;
                end else begin
                    o_ctl.lin_step = 1'b1;
                    o_ctl.rsel     = RA_K1;
                end
            end
            S_FIRST: begin
                o_ctl.ld_carry = 1'b1;
                o_ctl.rsel     = RA_K1;
                n_state        = S_STEP;
            end
            S_STEP: begin
                // write the smaller word back; unless at the limit, fetch the one after next
                o_ctl.sort_step = 1'b1;
                if (i_stat.k1_eq_lim) begin
                    n_state = S_END;
                end else begin
                    o_ctl.rsel = RA_K2;
                end
            end
            S_END: begin
                o_ctl.sort_end = 1'b1;
                if (i_stat.lim_gt1) begin
                    o_ctl.rsel = RA_ZERO;
                    n_state    = S_FIRST;
                end else begin
                    n_state = S_BSET;
                end
            end
            S_BSET: begin
                o_ctl.bin_init = 1'b1;
                n_state        = S_BADDR;
            end
            S_BADDR: begin
                if (i_stat.bin_open) begin
                    o_ctl.rsel         = RA_MID;
                    o_ctl.bin_load_mid = 1'b1;
                    n_state            = S_BCMP;
                end else begin
                    o_ctl.fin        = 1'b1;
                    o_ctl.fin_status = ST_NOT_FOUND;
                    n_state          = S_IDLE;
                end
            end
            S_BCMP: begin
                if (i_stat.eq) begin
                    o_ctl.fin        = 1'b1;
                    o_ctl.fin_status = ST_FOUND;
                    n_state          = S_IDLE;
                end else begin
                    o_ctl.bin_update = 1'b1;
                    n_state          = S_BADDR;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
